// ===== rtl/lru_key_value_cache_macros.svh =====
// Assertion macros for the LRU key-value cache.
`ifndef LRU_KEY_VALUE_CACHE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_MACROS_SVH
`ifndef SYNTHESIS
`define LKVC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lkvc assertion failed");
`define LKVC_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("lkvc forbidden condition seen");
`else
`define LKVC_ASSERT(label, clk, rst_n, prop)
`define LKVC_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ===== rtl/lkvc_pkg.sv =====
// Shared types and constants for the LRU key-value cache.
`timescale 1ns / 1ps
package lkvc_pkg;

    localparam int CAP_BITS  = 5;
    localparam int ADDR_BITS = 3;

    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

    // register index taken from paddr[2]
    localparam logic REG_CAPACITY = 1'b0;

    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_PUT = 1'b1;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } lkvc_state_t;

    typedef struct packed
    {
        logic cmp;
        logic load;
    } cell_ctl_t;

endpackage

// ===== rtl/lru_key_value_cache.sv =====
// Top level of the LRU key-value cache: item handshake, control and the cell chain.
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tuser: mode; tdata: key, value
//  m_axis    out  m_axis_tvalid/m_axis_tready   tuser: found; tdata: read_value
//  apb       in   psel/penable/pwrite/pready    capacity at byte address 0
//
//  Each item goes through a compare state, which compares its key in every cell, then an
//  update state, which encodes the hit and shifts the chain and may take the next item.
//  Cells stay ordered most recent first; the update cycle moves a run of cells by one.
//  Reset empties the chain at once and sets capacity to 16.
//  A result that is not taken holds the update cycle and the input side.
`timescale 1ns / 1ps
module lru_key_value_cache #(
    parameter int MAX_ENTRIES = 16,
    parameter int KEY_BITS    = 32,
    parameter int VALUE_BITS  = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [KEY_BITS-1:0] key, then value, zero padded to bytes
    input  logic [((KEY_BITS+VALUE_BITS+7)/8)*8-1:0] s_axis_tdata,
    // [0] mode
    input  logic [0:0]                             s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // [VALUE_BITS-1:0] read_value, zero padded to bytes
    output logic [((VALUE_BITS+7)/8)*8-1:0]        m_axis_tdata,
    // [0] found
    output logic [0:0]                             m_axis_tuser,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [lkvc_pkg::ADDR_BITS-1:0]         paddr,
    input  logic [31:0]                            pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);
    `include "lru_key_value_cache_macros.svh"
    import lkvc_pkg::*;

    localparam int IW    = $clog2(MAX_ENTRIES);
    localparam int OW    = $clog2(MAX_ENTRIES + 1);
    localparam int CW    = (OW > CAP_BITS) ? OW : CAP_BITS;
    localparam int OUT_W = ((VALUE_BITS + 7) / 8) * 8;

    lkvc_state_t state_reg, state_next;

    logic                  mode_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic [OW-1:0]         occ_reg, occ_next;
    logic [CAP_BITS-1:0]   cap_reg;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_found_reg;
    logic [VALUE_BITS-1:0] out_value_reg;

    logic in_accept;
    logic out_free;
    logic finish;
    logic do_update;
    logic cfg_write;

    logic [MAX_ENTRIES-1:0]                 valid_vec;
    logic [MAX_ENTRIES-1:0]                 match_vec;
    logic [MAX_ENTRIES-1:0][KEY_BITS-1:0]   key_vec;
    logic [MAX_ENTRIES-1:0][VALUE_BITS-1:0] value_vec;
    logic [MAX_ENTRIES-1:0]                 load_vec;

    logic                  found;
    logic [IW-1:0]         hit_idx;
    logic [VALUE_BITS-1:0] hit_value;
    logic [VALUE_BITS-1:0] head_value;
    logic [CW-1:0]         eff_cap;
    logic [CW-1:0]         cap_ext;
    logic                  evict;
    logic [IW-1:0]         ins_pos;
    logic [IW-1:0]         upd_pos;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_CAPACITY) ? 32'(cap_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_write && (paddr[2] == REG_CAPACITY))
        begin
            cap_reg <= pwdata[CAP_BITS-1:0];
        end
    end

    // capacity zero acts as one, above the chain length as the chain length
    assign cap_ext = CW'(cap_reg);
    always_comb
    begin
        priority if (cap_reg == '0)
            eff_cap = CW'(1);
        else if (cap_ext > CW'(MAX_ENTRIES))
            eff_cap = CW'(MAX_ENTRIES);
        else
            eff_cap = cap_ext;
    end

    assign evict   = CW'(occ_reg) >= eff_cap;
    assign ins_pos = evict ? IW'(occ_reg - OW'(1)) : IW'(occ_reg);
    assign upd_pos = found ? hit_idx : ins_pos;

    // ---------------- control ----------------
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_free  = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        state_next    = state_reg;
        s_axis_tready = 1'b0;
        finish        = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                    state_next = ST_CMP;
            end
            ST_CMP:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                s_axis_tready = out_free;
                if (out_free)
                begin
                    finish     = 1'b1;
                    state_next = s_axis_tvalid ? ST_CMP : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign do_update = finish && (found || (mode_reg == MODE_PUT));

    always_comb
    begin
        occ_next = occ_reg;
        if (do_update && !found && !evict)
            occ_next = occ_reg + OW'(1);
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (finish)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            mode_reg  <= s_axis_tuser[0];
            key_reg   <= s_axis_tdata[KEY_BITS-1:0];
            value_reg <= s_axis_tdata[KEY_BITS+VALUE_BITS-1:KEY_BITS];
        end
        if (finish)
        begin
            out_found_reg <= found;
            out_value_reg <= (found && (mode_reg == MODE_GET)) ? hit_value : '0;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tuser[0] = out_found_reg;
    assign m_axis_tdata    = OUT_W'(out_value_reg);

    // ---------------- hit encode ----------------
    lkvc_hit_enc #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .VALUE_BITS  (VALUE_BITS)
    ) u_hit_enc (
        .match_vec (match_vec),
        .value_vec (value_vec),
        .found     (found),
        .hit_idx   (hit_idx),
        .hit_value (hit_value)
    );

    // a put writes its own value at the head, a get carries the old one forward
    assign head_value = (mode_reg == MODE_PUT) ? value_reg : hit_value;

    // ---------------- cell chain ----------------
    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        cell_ctl_t             ctl;
        logic                  prev_valid;
        logic [KEY_BITS-1:0]   prev_key;
        logic [VALUE_BITS-1:0] prev_value;

        // advance every cell from the head down to the updated position
        assign load_vec[i] = do_update && (IW'(i) <= upd_pos);
        assign ctl.cmp     = (state_reg == ST_CMP);
        assign ctl.load    = load_vec[i];

        if (i == 0)
        begin : g_head
            assign prev_valid = 1'b1;
            assign prev_key   = key_reg;
            assign prev_value = head_value;
        end
        else
        begin : g_body
            assign prev_valid = valid_vec[i-1];
            assign prev_key   = key_vec[i-1];
            assign prev_value = value_vec[i-1];
        end

        lkvc_cell #(
            .KEY_BITS   (KEY_BITS),
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .prev_valid (prev_valid),
            .prev_key   (prev_key),
            .prev_value (prev_value),
            .item_key   (key_reg),
            .valid      (valid_vec[i]),
            .key        (key_vec[i]),
            .value      (value_vec[i]),
            .match      (match_vec[i])
        );
    end

    // ---------------- assertions ----------------
    `LKVC_ASSERT(a_match_onehot, clk, rst_n, (state_reg == ST_UPD) |-> $onehot0(match_vec))
    `LKVC_ASSERT(a_occ_count, clk, rst_n, $countones(valid_vec) == int'(occ_reg))
    `LKVC_NEVER(a_valid_prefix, clk, rst_n, (valid_vec & (valid_vec + MAX_ENTRIES'(1))) != '0)
    `LKVC_NEVER(a_no_take_in_cmp, clk, rst_n, (state_reg == ST_CMP) && s_axis_tready)
    `LKVC_ASSERT(a_result_after_upd, clk, rst_n, finish |=> m_axis_tvalid)

endmodule

// ===== rtl/lkvc_cell.sv =====
// One entry of the recency-ordered chain: holds a key/value pair and takes its neighbor's.
`timescale 1ns / 1ps
module lkvc_cell #(
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  lkvc_pkg::cell_ctl_t    ctl,
    input  logic                   prev_valid,
    input  logic [KEY_BITS-1:0]    prev_key,
    input  logic [VALUE_BITS-1:0]  prev_value,
    input  logic [KEY_BITS-1:0]    item_key,
    output logic                   valid,
    output logic [KEY_BITS-1:0]    key,
    output logic [VALUE_BITS-1:0]  value,
    output logic                   match
);
    import lkvc_pkg::*;

    logic                  valid_reg;
    logic                  match_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            if (ctl.cmp)
            begin
                match_reg <= valid_reg && (key_reg == item_key);
            end
            if (ctl.load)
            begin
                valid_reg <= prev_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            key_reg   <= prev_key;
            value_reg <= prev_value;
        end
    end

    assign valid = valid_reg;
    assign key   = key_reg;
    assign value = value_reg;
    assign match = match_reg;

endmodule

// ===== rtl/lkvc_hit_enc.sv =====
// Encode the one-hot match row into a position and select the matching value.
`timescale 1ns / 1ps
module lkvc_hit_enc #(
    parameter int MAX_ENTRIES = 16,
    parameter int VALUE_BITS  = 32
) (
    input  logic [MAX_ENTRIES-1:0]                 match_vec,
    input  logic [MAX_ENTRIES-1:0][VALUE_BITS-1:0] value_vec,
    output logic                                   found,
    output logic [$clog2(MAX_ENTRIES)-1:0]         hit_idx,
    output logic [VALUE_BITS-1:0]                  hit_value
);
    import lkvc_pkg::*;

    localparam int IW = $clog2(MAX_ENTRIES);

    // keys are unique among valid entries, so at most one match bit is set
    always_comb
    begin
        logic [IW-1:0]         idx;
        logic [VALUE_BITS-1:0] val;
        idx = '0;
        val = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            if (match_vec[i])
            begin
                idx = idx | IW'(i);
                val = val | value_vec[i];
            end
        end
        hit_idx   = idx;
        hit_value = val;
    end

    assign found = |match_vec;

endmodule

// ===== tb/sv/tb_lru_key_value_cache.sv =====
// Self-checking testbench for the LRU key-value cache: stream items, APB capacity writes.
`timescale 1ns / 1ps
module tb_lru_key_value_cache;
    import lkvc_pkg::*;

    localparam int SLOTS        = 16;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 400000;

    localparam logic [ADDR_BITS-1:0] ADDR_CAPACITY = {REG_CAPACITY, 2'b00};
    // index 1: no register lives here, writes must be ignored
    localparam logic [ADDR_BITS-1:0] ADDR_SPARE    = {~REG_CAPACITY, 2'b00};

    typedef struct packed
    {
        logic        found;
        logic [31:0] read_value;
    } reply_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [63:0]          s_axis_tdata;   // [31:0] key, [63:32] value
    logic [0:0]           s_axis_tuser;   // [0] mode
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [31:0]          m_axis_tdata;   // [31:0] read_value
    logic [0:0]           m_axis_tuser;   // [0] found
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    // predicted cache contents
    logic                slot_used [SLOTS];
    logic [31:0]         slot_key  [SLOTS];
    logic [31:0]         slot_val  [SLOTS];
    int unsigned         slot_age  [SLOTS];
    int unsigned         fill_count;
    logic [CAP_BITS-1:0] capacity_reg;

    reply_t      expected_replies[$];
    logic [31:0] key_pool[32];

    int          error_count;
    int          words_sent;
    int          words_checked;
    int          config_writes;
    int          cycle_count;
    int          hold_off_len;
    bit          src_idle_en;
    bit          sink_idle_en;

    lru_key_value_cache i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d replies outstanding", cycle_count,
                     expected_replies.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // One get or put against the predicted cache; returns the reply it produces.
    function automatic reply_t lru_access(logic mode, logic [31:0] key, logic [31:0] value);
        reply_t      r;
        int          hit;
        int          victim;
        int          free_slot;
        int unsigned age;
        int unsigned limit;
        hit = -1;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (slot_used[i] && slot_key[i] == key && hit < 0)
                hit = i;
        end
        r.found      = (hit >= 0);
        r.read_value = '0;
        if (hit >= 0)
        begin
            if (mode == MODE_GET)
                r.read_value = slot_val[hit];
            else
                slot_val[hit] = value;
            age = slot_age[hit];
            for (int i = 0; i < SLOTS; i++)
            begin
                if (slot_used[i] && slot_age[i] < age)
                    slot_age[i]++;
            end
            slot_age[hit] = 0;
        end
        else if (mode == MODE_PUT)
        begin
            limit = (capacity_reg == 0) ? 1 : (capacity_reg > SLOTS) ? SLOTS : capacity_reg;
            if (fill_count + 1 > limit)
            begin
                victim = -1;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (slot_used[i] && (victim < 0 || slot_age[i] > slot_age[victim]))
                        victim = i;
                end
                if (victim >= 0)
                begin
                    slot_used[victim] = 1'b0;
                    slot_age[victim]  = 0;
                    fill_count--;
                end
            end
            free_slot = -1;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (!slot_used[i] && free_slot < 0)
                    free_slot = i;
            end
            if (free_slot >= 0)
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (slot_used[i])
                        slot_age[i]++;
                end
                slot_used[free_slot] = 1'b1;
                slot_key[free_slot]  = key;
                slot_val[free_slot]  = value;
                slot_age[free_slot]  = 0;
                fill_count++;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH reply %0d %s: got %h, want %h", words_checked, what, got, want);
        error_count++;
    endtask

    // Compare every reply taken from the block with the oldest prediction.
    initial
    begin
        reply_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                if (expected_replies.size() == 0)
                begin
                    report_mismatch("unexpected word", {31'b0, m_axis_tuser[0]}, '0);
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (m_axis_tuser[0] !== want.found)
                        report_mismatch("found", {31'b0, m_axis_tuser[0]}, {31'b0, want.found});
                    if (m_axis_tdata !== want.read_value)
                        report_mismatch("read_value", m_axis_tdata, want.read_value);
                end
                words_checked++;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request.
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_len > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (hold_off_len) @(posedge clk);
                hold_off_len = 0;
                m_axis_tready <= 1'b1;
            end
            else if (sink_idle_en && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic apb_write(logic [ADDR_BITS-1:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr[2] == REG_CAPACITY)
            capacity_reg = data[CAP_BITS-1:0];
        config_writes++;
    endtask

    task automatic send_item(logic mode, logic [31:0] key, logic [31:0] value);
        if (src_idle_en && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {value, key};
        s_axis_tuser  <= mode;
        expected_replies.push_back(lru_access(mode, key, value));
        do
            @(posedge clk);
        while (!s_axis_tready);
        words_sent++;
    endtask

    // Hold the sender until every predicted reply has come back.
    task automatic drain_replies();
        s_axis_tvalid <= 1'b0;
        while (expected_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic refill_key_pool();
        for (int i = 0; i < 32; i++)
            key_pool[i] = $urandom;
        key_pool[3] = 32'h8000_0000;
        key_pool[5] = 32'h7FFF_FFFF;
    endtask

    task automatic send_random(int pool_n);
        logic        mode;
        logic [31:0] key;
        logic [31:0] value;
        mode  = 1'($urandom_range(0, 1));
        key   = ($urandom_range(0, 9) == 0) ? $urandom
                : key_pool[5'($urandom_range(0, pool_n - 1))];
        value = $urandom;
        case ($urandom_range(0, 15))
            0:       value = 32'h8000_0000;
            1:       value = 32'h7FFF_FFFF;
            2:       value = 32'hFFFF_FFFF;
            3:       value = 32'h0000_0000;
            default: ;
        endcase
        send_item(mode, key, value);
    endtask

    task automatic test_basic_ops();
        send_item(MODE_GET, 32'h0000_0000, 32'h0);
        send_item(MODE_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(MODE_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(MODE_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(MODE_PUT, 32'h0000_0000, 32'h0000_0000);
        send_item(MODE_GET, 32'h8000_0000, 32'hFFFF_FFFF);
        send_item(MODE_GET, 32'h7FFF_FFFF, 32'h0);
        send_item(MODE_GET, 32'hFFFF_FFFF, 32'h0);
        send_item(MODE_GET, 32'h0000_0000, 32'h5555_AAAA);
        // overwrite on a put hit reports found with a zero value
        send_item(MODE_PUT, 32'h8000_0000, 32'h1234_5678);
        send_item(MODE_GET, 32'h8000_0000, 32'h0);
        send_item(MODE_GET, 32'h0000_0001, 32'hFFFF_FFFF);
        send_item(MODE_GET, 32'hFFFF_FFFE, 32'h0);
        drain_replies();
    endtask

    task automatic test_capacity_limits();
        apb_write(ADDR_CAPACITY, 32'd1);
        drain_replies();
        send_item(MODE_PUT, 32'h0000_00A1, 32'h1111_1111);
        send_item(MODE_PUT, 32'h0000_00B2, 32'h2222_2222);
        send_item(MODE_GET, 32'h0000_00A1, 32'h0);
        send_item(MODE_GET, 32'h0000_00B2, 32'h0);
        drain_replies();
        // zero behaves as one
        apb_write(ADDR_CAPACITY, 32'd0);
        drain_replies();
        send_item(MODE_PUT, 32'h0000_00C3, 32'h3333_3333);
        send_item(MODE_GET, 32'h0000_00B2, 32'h0);
        send_item(MODE_GET, 32'h0000_00C3, 32'h0);
        drain_replies();
        // above the slot count behaves as the slot count; upper bits masked off
        apb_write(ADDR_CAPACITY, 32'hFFFF_FFFF);
        drain_replies();
        for (int i = 0; i < SLOTS + 2; i++)
            send_item(MODE_PUT, 32'h0000_1000 + i, $urandom);
        send_item(MODE_GET, 32'h0000_1000, 32'h0);
        send_item(MODE_GET, 32'h0000_1002, 32'h0);
        drain_replies();
    endtask

    task automatic test_capacity_lowered();
        // full at sixteen, then shrink: each insert drops just one entry
        apb_write(ADDR_CAPACITY, 32'd2);
        drain_replies();
        send_item(MODE_GET, 32'h0000_1005, 32'h0);
        send_item(MODE_PUT, 32'h0000_2000, 32'hDEAD_BEEF);
        send_item(MODE_PUT, 32'h0000_2001, 32'hCAFE_F00D);
        send_item(MODE_GET, 32'h0000_1003, 32'h0);
        send_item(MODE_GET, 32'h0000_1004, 32'h0);
        send_item(MODE_GET, 32'h0000_1011, 32'h0);
        drain_replies();
    endtask

    task automatic test_spare_register();
        apb_write(ADDR_CAPACITY, 32'd16);
        drain_replies();
        apb_write(ADDR_SPARE, 32'd1);
        drain_replies();
        send_item(MODE_PUT, 32'h0000_3000, 32'h0000_0001);
        send_item(MODE_PUT, 32'h0000_3001, 32'h0000_0002);
        send_item(MODE_GET, 32'h0000_3000, 32'h0);
        send_item(MODE_GET, 32'h0000_3001, 32'h0);
        drain_replies();
    endtask

    task automatic run_random_phase(int cap, int count, int pool_n);
        refill_key_pool();
        apb_write(ADDR_CAPACITY, {27'($urandom_range(0, 32'h07FF_FFFF)), cap[4:0]});
        drain_replies();
        for (int i = 0; i < count; i++)
        begin
            send_random(pool_n);
            // at random, pause the sender mid-phase until the block has answered everything
            if (i == count / 2 && $urandom_range(0, 1) == 0)
                drain_replies();
        end
        drain_replies();
    endtask

    task automatic test_random_settings();
        run_random_phase(16, 200, 20);
        run_random_phase(1, 120, 3);
        run_random_phase(0, 120, 3);
        run_random_phase(31, 200, 24);
        run_random_phase(4, 150, 7);
        run_random_phase(17, 150, 22);
        run_random_phase(8, 150, 12);
        run_random_phase(2, 120, 4);
    endtask

    task automatic test_output_backpressure();
        refill_key_pool();
        apb_write(ADDR_CAPACITY, 32'd6);
        drain_replies();
        src_idle_en  = 1'b0;
        hold_off_len = 300;
        for (int i = 0; i < 60; i++)
            send_random(10);
        drain_replies();
        src_idle_en = 1'b1;
    endtask

    task automatic test_full_rate();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        run_random_phase(16, 150, 20);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = MODE_GET;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        error_count   = 0;
        words_sent    = 0;
        words_checked = 0;
        config_writes = 0;
        cycle_count   = 0;
        hold_off_len  = 0;
        src_idle_en   = 1'b1;
        sink_idle_en  = 1'b1;
        fill_count    = 0;
        capacity_reg  = CAP_RESET;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_used[i] = 1'b0;
            slot_key[i]  = '0;
            slot_val[i]  = '0;
            slot_age[i]  = 0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_ops();
        test_capacity_limits();
        test_capacity_lowered();
        test_spare_register();
        test_random_settings();
        test_output_backpressure();
        test_full_rate();

        $display("sent %0d gets/puts, checked %0d replies, %0d register writes",
                 words_sent, words_checked, config_writes);
        $display("capacities 0, 1, 2, 4, 6, 8, 16, 17, 31 with eviction, shrink and stalls");
        if (error_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
